[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg : complex arithmetic unit package
// Item types, action codes and status codes shared by all stages.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned MAG_W  = 64;
  localparam int unsigned SUM_W  = 65;
  localparam int unsigned QBITS  = 33;   // quotient bits 32..0, one per cell
  localparam int unsigned ST_W   = 2;

  // action codes
  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_CMP = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_DZ  = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT = 2'd2;

  // any magnitude above 2^31 saturates either sign
  localparam logic [MAG_W-1:0] SAT_MAG = 64'h0000_0000_8000_0001;
  localparam logic [MAG_W-1:0] NEG_LIM = 64'h0000_0000_8000_0000;
  localparam logic [MAG_W-1:0] POS_LIM = 64'h0000_0000_7FFF_FFFF;

  typedef struct packed {
    logic [OP_W-1:0]          action;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic                     is_equal;
    logic [ST_W-1:0]          status;
  } cau_out_t;

  // work item as it travels along the divider cells
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             neg_re;
    logic             neg_im;
    logic [MAG_W-1:0] mag_re;   // magnitude, or partial remainder for divide
    logic [MAG_W-1:0] mag_im;
    logic [QBITS-1:0] nq_re;    // dividend bits out, quotient bits in
    logic [QBITS-1:0] nq_im;
    logic [MAG_W-1:0] den;
    logic             ovf_re;
    logic             ovf_im;
    logic             eq;
    logic             dz;
  } cau_cell_t;

endpackage

`default_nettype wire

[rtl/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front : product, sum, sign split and divider set-up stages
// Four registered stages that turn an input item into a cell item.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire cau_in_t   in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output cau_cell_t      out_o
);

  localparam int unsigned NUM_W = MAG_W + FRAC_BITS;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ri;
    logic signed [PROD_W-1:0] p_ir;
    logic signed [PROD_W-1:0] q_rr;
    logic signed [PROD_W-1:0] q_ii;
  } prod_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [SUM_W-1:0] s_re;
    logic signed [SUM_W-1:0] s_im;
    logic [MAG_W-1:0]        den;
    logic                    eq;
    logic                    dz;
  } sum_t;

  logic      a_v_q, b_v_q, c_v_q, d_v_q;
  logic      a_en, b_en, c_en, d_en;
  prod_t     a_q, a_d;
  sum_t      b_q, b_d;
  cau_cell_t c_q, c_d, d_q, d_d;

  assign d_en       = !d_v_q || out_ready_i;
  assign c_en       = !c_v_q || d_en;
  assign b_en       = !b_v_q || c_en;
  assign a_en       = !a_v_q || b_en;
  assign in_ready_o = a_en;

  // stage A: products
  always_comb begin
    a_d.op   = in_i.action;
    a_d.a_re = in_i.a_re;
    a_d.a_im = in_i.a_im;
    a_d.b_re = in_i.b_re;
    a_d.b_im = in_i.b_im;
    a_d.p_rr = in_i.a_re * in_i.b_re;
    a_d.p_ii = in_i.a_im * in_i.b_im;
    a_d.p_ri = in_i.a_re * in_i.b_im;
    a_d.p_ir = in_i.a_im * in_i.b_re;
    a_d.q_rr = in_i.b_re * in_i.b_re;
    a_d.q_ii = in_i.b_im * in_i.b_im;
  end

  // stage B: exact sums per action
  always_comb begin
    b_d.op  = a_q.op;
    b_d.den = $unsigned(a_q.q_rr) + $unsigned(a_q.q_ii);
    b_d.dz  = (a_q.b_re == '0) && (a_q.b_im == '0);
    b_d.eq  = (a_q.op == OP_CMP) && (a_q.a_re == a_q.b_re) && (a_q.a_im == a_q.b_im);
    unique case (a_q.op)
      OP_ADD: begin
        b_d.s_re = SUM_W'(a_q.a_re) + SUM_W'(a_q.b_re);
        b_d.s_im = SUM_W'(a_q.a_im) + SUM_W'(a_q.b_im);
      end
      OP_SUB: begin
        b_d.s_re = SUM_W'(a_q.a_re) - SUM_W'(a_q.b_re);
        b_d.s_im = SUM_W'(a_q.a_im) - SUM_W'(a_q.b_im);
      end
      OP_MUL: begin
        b_d.s_re = SUM_W'(a_q.p_rr) - SUM_W'(a_q.p_ii);
        b_d.s_im = SUM_W'(a_q.p_ri) + SUM_W'(a_q.p_ir);
      end
      OP_DIV: begin
        b_d.s_re = SUM_W'(a_q.p_rr) + SUM_W'(a_q.p_ii);
        b_d.s_im = SUM_W'(a_q.p_ir) - SUM_W'(a_q.p_ri);
      end
      default: begin
        b_d.s_re = '0;
        b_d.s_im = '0;
      end
    endcase
  end

  // stage C: sign and magnitude
  always_comb begin
    c_d        = '0;
    c_d.op     = b_q.op;
    c_d.den    = b_q.den;
    c_d.eq     = b_q.eq;
    c_d.dz     = b_q.dz;
    c_d.neg_re = b_q.s_re[SUM_W-1];
    c_d.neg_im = b_q.s_im[SUM_W-1];
    c_d.mag_re = MAG_W'(b_q.s_re[SUM_W-1] ? -b_q.s_re : b_q.s_re);
    c_d.mag_im = MAG_W'(b_q.s_im[SUM_W-1] ? -b_q.s_im : b_q.s_im);
  end

  // stage D: split the scaled dividend into the top remainder and the
  // bits still to be brought down; the top part alone reaching the
  // divisor means the quotient is far beyond range
  always_comb begin
    logic [NUM_W-1:0] num_re;
    logic [NUM_W-1:0] num_im;
    num_re = NUM_W'(c_q.mag_re) << FRAC_BITS;
    num_im = NUM_W'(c_q.mag_im) << FRAC_BITS;
    d_d    = c_q;
    if (c_q.op == OP_DIV) begin
      d_d.mag_re = MAG_W'(num_re >> QBITS);
      d_d.mag_im = MAG_W'(num_im >> QBITS);
      d_d.nq_re  = num_re[QBITS-1:0];
      d_d.nq_im  = num_im[QBITS-1:0];
      d_d.ovf_re = MAG_W'(num_re >> QBITS) >= c_q.den;
      d_d.ovf_im = MAG_W'(num_im >> QBITS) >= c_q.den;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (a_en) a_v_q <= in_valid_i;
      if (b_en) b_v_q <= a_v_q;
      if (c_en) c_v_q <= b_v_q;
      if (d_en) d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && in_valid_i) a_q <= a_d;
    if (b_en && a_v_q)      b_q <= b_d;
    if (c_en && b_v_q)      c_q <= c_d;
    if (d_en && c_v_q)      d_q <= d_d;
  end

  assign out_valid_o = d_v_q;
  assign out_o       = d_q;

endmodule

`default_nettype wire

[rtl/cau_div_cell.sv]
// ----------------------------------------------------------------------------
// cau_div_cell : one restoring division step
// Brings down one dividend bit and settles one quotient bit per part.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_cell import cau_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire cau_cell_t in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output cau_cell_t      out_o
);

  logic      v_q;
  logic      en;
  cau_cell_t d_q, d_d;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    logic [MAG_W:0] t_re;
    logic [MAG_W:0] t_im;
    logic [MAG_W:0] dv;
    logic           ge_re;
    logic           ge_im;
    t_re  = {in_i.mag_re, in_i.nq_re[QBITS-1]};
    t_im  = {in_i.mag_im, in_i.nq_im[QBITS-1]};
    dv    = {1'b0, in_i.den};
    ge_re = t_re >= dv;
    ge_im = t_im >= dv;
    d_d   = in_i;
    if (in_i.op == OP_DIV) begin
      d_d.mag_re = MAG_W'(ge_re ? t_re - dv : t_re);
      d_d.mag_im = MAG_W'(ge_im ? t_im - dv : t_im);
      d_d.nq_re  = {in_i.nq_re[QBITS-2:0], ge_re};
      d_d.nq_im  = {in_i.nq_im[QBITS-2:0], ge_im};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) d_q <= d_d;
  end

  assign out_valid_o = v_q;
  assign out_o       = d_q;

endmodule

`default_nettype wire

[rtl/cau_back.sv]
// ----------------------------------------------------------------------------
// cau_back : rounding and saturating pack
// Picks base magnitude and round bit per action, then clamps to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire cau_cell_t in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output cau_out_t       out_o
);

  localparam logic [MAG_W-1:0] HALF = (MAG_W'(1) << FRAC_BITS) >> 1;

  typedef struct packed {
    logic             neg_re;
    logic             neg_im;
    logic [MAG_W-1:0] base_re;
    logic [MAG_W-1:0] base_im;
    logic             rnd_re;
    logic             rnd_im;
    logic             eq;
    logic             dz;
  } rnd_t;

  logic     r_v_q, p_v_q;
  logic     r_en, p_en;
  rnd_t     r_q, r_d;
  cau_out_t p_q, p_d;

  assign p_en       = !p_v_q || out_ready_i;
  assign r_en       = !r_v_q || p_en;
  assign in_ready_o = r_en;

  // round stage
  always_comb begin
    r_d        = '0;
    r_d.eq     = in_i.eq;
    unique case (in_i.op) inside
      OP_ADD, OP_SUB: begin
        r_d.neg_re  = in_i.neg_re;
        r_d.neg_im  = in_i.neg_im;
        r_d.base_re = in_i.mag_re;
        r_d.base_im = in_i.mag_im;
      end
      OP_MUL: begin
        r_d.neg_re  = in_i.neg_re;
        r_d.neg_im  = in_i.neg_im;
        r_d.base_re = in_i.mag_re >> FRAC_BITS;
        r_d.base_im = in_i.mag_im >> FRAC_BITS;
        r_d.rnd_re  = |(in_i.mag_re & HALF);
        r_d.rnd_im  = |(in_i.mag_im & HALF);
      end
      OP_DIV: begin
        r_d.dz = in_i.dz;
        if (!in_i.dz) begin
          r_d.neg_re  = in_i.neg_re;
          r_d.neg_im  = in_i.neg_im;
          r_d.base_re = in_i.ovf_re ? SAT_MAG : MAG_W'(in_i.nq_re);
          r_d.base_im = in_i.ovf_im ? SAT_MAG : MAG_W'(in_i.nq_im);
          r_d.rnd_re  = !in_i.ovf_re && ({in_i.mag_re, 1'b0} >= {1'b0, in_i.den});
          r_d.rnd_im  = !in_i.ovf_im && ({in_i.mag_im, 1'b0} >= {1'b0, in_i.den});
        end
      end
      default: begin
        r_d.eq = in_i.eq;
      end
    endcase
  end

  // pack stage
  always_comb begin
    logic [MAG_W-1:0] m_re;
    logic [MAG_W-1:0] m_im;
    logic             sat_re;
    logic             sat_im;
    m_re   = r_q.base_re + MAG_W'(r_q.rnd_re);
    m_im   = r_q.base_im + MAG_W'(r_q.rnd_im);
    sat_re = r_q.neg_re ? (m_re > NEG_LIM) : (m_re > POS_LIM);
    sat_im = r_q.neg_im ? (m_im > NEG_LIM) : (m_im > POS_LIM);
    if (r_q.neg_re) p_d.res_re = sat_re ? 32'sh8000_0000 : DATA_W'(MAG_W'(0) - m_re);
    else            p_d.res_re = sat_re ? 32'sh7FFF_FFFF : DATA_W'(m_re);
    if (r_q.neg_im) p_d.res_im = sat_im ? 32'sh8000_0000 : DATA_W'(MAG_W'(0) - m_im);
    else            p_d.res_im = sat_im ? 32'sh7FFF_FFFF : DATA_W'(m_im);
    p_d.is_equal = r_q.eq;
    if (r_q.dz)                p_d.status = ST_DZ;
    else if (sat_re || sat_im) p_d.status = ST_SAT;
    else                       p_d.status = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
      p_v_q <= 1'b0;
    end else begin
      if (r_en) r_v_q <= in_valid_i;
      if (p_en) p_v_q <= r_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_en && in_valid_i) r_q <= r_d;
    if (p_en && r_v_q)      p_q <= p_d;
  end

  assign out_valid_o = p_v_q;
  assign out_o       = p_q;

endmodule

`default_nettype wire

[rtl/complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit : pipelined complex ALU, signed fixed point
// Add, subtract, multiply, divide and compare on Q(32-F).F operands.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_i  (action, a, b)
//  out     | output    | out_valid_o/out_ready_i| out_o (res, is_equal, status)
//
//  One item per cycle while the output keeps taking results. Every item
//  passes four front stages, 33 divider cells, round and pack between
//  acceptance and result; most of them are the divider cells, one
//  quotient bit each. Every stage holds its own valid bit, so bubbles
//  close up and a new item is taken while a finished result waits at the output, as long as a stage is empty.
//  Reset clears the valid bits only; no clearing pass is needed.
//
// Multiply and divide products are 32x32 in the first stage. Divide forms
// the conjugate product sums and |b|^2, then long division of the sums
// scaled by 2^FRAC_BITS brings down one bit per cell. A dividend whose
// top part already reaches the divisor is flagged as saturating. The last
// stages add the round bit (ties away from zero) and clamp to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire cau_in_t in_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output cau_out_t     out_o
);

  // chain links: index 0 is the front output, QBITS the last cell output
  logic      cv [QBITS+1];
  logic      cr [QBITS+1];
  cau_cell_t cd [QBITS+1];

  cau_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (cv[0]),
    .out_ready_i (cr[0]),
    .out_o       (cd[0])
  );

  for (genvar g = 0; g < QBITS; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cv[g]),
      .in_ready_o  (cr[g]),
      .in_i        (cd[g]),
      .out_valid_o (cv[g+1]),
      .out_ready_i (cr[g+1]),
      .out_o       (cd[g+1])
    );
  end

  cau_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cv[QBITS]),
    .in_ready_o  (cr[QBITS]),
    .in_i        (cd[QBITS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[verif/tb_complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit : self-checking bench for the complex ALU
// Directed table then random items through the valid/ready channels; every
// result is checked field by field against a typed-in or predicted value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = 39;
  localparam longint CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  cau_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cau_out_t out_item;

  always #5 clk = ~clk;

  complex_arithmetic_unit #(.FRAC_BITS(FRAC)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_item)
  );

  // --------------------------------------------------------------------------
  // Predictor. Products are formed exactly at 128 bits, so no wrap occurs.
  // --------------------------------------------------------------------------
  typedef logic signed [127:0] wide_t;

  // clamp to the 32-bit range, flagging saturation
  function automatic logic [31:0] clamp32(input wide_t v, inout logic sat);
    if (v > wide_t'(64'sh7FFF_FFFF)) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -wide_t'(64'sh8000_0000)) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // shift right by FRAC, round to nearest, ties away from zero
  function automatic wide_t shift_nearest(input wide_t v);
    wide_t m;
    m = (v < 0) ? -v : v;
    m = (m + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
    return (v < 0) ? -m : m;
  endfunction

  // v * 2^FRAC / den, rounded the same way; den is positive
  function automatic wide_t div_nearest(input wide_t v, input wide_t den);
    wide_t m, q, r;
    m = (v < 0) ? -v : v;
    m = m <<< FRAC;
    q = m / den;
    r = m % den;
    if (2 * r >= den) q = q + 1;
    return (v < 0) ? -q : q;
  endfunction

  function automatic cau_out_t alu_result(input cau_in_t x);
    cau_out_t r;
    wide_t ar, ai, br, bi, den;
    logic sat;
    r = '0;
    sat = 1'b0;
    ar = wide_t'(x.a_re);
    ai = wide_t'(x.a_im);
    br = wide_t'(x.b_re);
    bi = wide_t'(x.b_im);
    case (x.action)
      OP_ADD: begin
        r.res_re = clamp32(ar + br, sat);
        r.res_im = clamp32(ai + bi, sat);
      end
      OP_SUB: begin
        r.res_re = clamp32(ar - br, sat);
        r.res_im = clamp32(ai - bi, sat);
      end
      OP_MUL: begin
        r.res_re = clamp32(shift_nearest(ar * br - ai * bi), sat);
        r.res_im = clamp32(shift_nearest(ar * bi + ai * br), sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.status = ST_DZ;
        else begin
          r.res_re = clamp32(div_nearest(ar * br + ai * bi, den), sat);
          r.res_im = clamp32(div_nearest(ai * br - ar * bi, den), sat);
        end
      end
      OP_CMP: r.is_equal = (x.a_re == x.b_re) && (x.a_im == x.b_im);
      default: ;
    endcase
    if (sat && r.status == ST_OK) r.status = ST_SAT;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Results awaited, oldest first
  // --------------------------------------------------------------------------
  cau_out_t pending_results[$];
  int       n_fail = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  logic     hold_req = 1'b0;   // raised once by the stimulus
  logic     hold_done = 1'b0;
  int       hold_cycles = 0;   // long receiver hold-off, counted down below
  longint   cycle_count = 0;

  // receiver: random stalls plus the one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done   <= 1'b1;
      hold_cycles <= 200;
      out_ready   <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // check each accepted item against the oldest expectation
  always @(posedge clk) begin
    cau_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.res_re !== want.res_re) begin
          $error("res_re: expected %h, got %h", want.res_re, out_item.res_re);
          n_fail++;
        end
        if (out_item.res_im !== want.res_im) begin
          $error("res_im: expected %h, got %h", want.res_im, out_item.res_im);
          n_fail++;
        end
        if (out_item.is_equal !== want.is_equal) begin
          $error("is_equal: expected %b, got %b", want.is_equal, out_item.is_equal);
          n_fail++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  typedef struct {
    cau_in_t  item;
    logic     known;    // expected result typed in below
    cau_out_t result;
  } stim_row_t;

  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MAXN = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  stim_row_t directed[$];

  // offer one item, hold it until taken, record the expectation on accept;
  // valid stays up after the accept so the next item can follow at once
  task automatic offer_item(input cau_in_t x, input cau_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= x;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(want);
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(5))
      0: return MAXP;
      1: return MAXN;
      2: return $urandom_range(3);
      3: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cau_in_t rand_item();
    cau_in_t x;
    x.action = $urandom_range(99) < 95 ? OP_W'($urandom_range(4)) : OP_W'($urandom_range(7));
    x.a_re = rand_part();
    x.a_im = rand_part();
    x.b_re = rand_part();
    x.b_im = $urandom_range(7) == 0 ? 32'd0 : rand_part();   // scalar forms
    if (x.action == OP_CMP && $urandom_range(1)) begin
      x.b_re = x.a_re;
      if ($urandom_range(1)) x.b_im = x.a_im;
    end
    if (x.action == OP_DIV && $urandom_range(15) == 0) begin
      x.b_re = '0;
      x.b_im = '0;
    end
    return x;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [31:0] ar,
                                  input logic [31:0] ai, input logic [31:0] br,
                                  input logic [31:0] bi, input logic known,
                                  input cau_out_t result);
    stim_row_t r;
    r.item   = '{action: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    r.known  = known;
    r.result = result;
    directed.push_back(r);
  endfunction

  initial begin
    cau_out_t none;
    cau_out_t want;
    cau_in_t  x;
    none = '0;

    // typed-in expectations: extremes, saturation, divide by zero, compare, multiply, unused codes
    add_row(OP_ADD, MAXP, MAXN, 1, 32'hFFFF_FFFF, 1'b1,
            '{res_re: MAXP, res_im: MAXN, is_equal: 1'b0, status: ST_SAT});
    add_row(OP_SUB, MAXN, MAXP, 1, 32'hFFFF_FFFF, 1'b1,
            '{res_re: MAXN, res_im: MAXP, is_equal: 1'b0, status: ST_SAT});
    add_row(OP_ADD, 0, 0, 0, 0, 1'b1, none);
    add_row(OP_DIV, ONE, ONE, 0, 0, 1'b1,
            '{res_re: 0, res_im: 0, is_equal: 1'b0, status: ST_DZ});
    add_row(OP_CMP, MAXN, MAXP, MAXN, MAXP, 1'b1,
            '{res_re: 0, res_im: 0, is_equal: 1'b1, status: ST_OK});
    add_row(OP_CMP, 5, 6, 5, 7, 1'b1, none);
    add_row(OP_MUL, ONE, ONE, ONE, 0, 1'b1,
            '{res_re: ONE, res_im: ONE, is_equal: 1'b0, status: ST_OK});
    add_row(3'd5, MAXP, MAXP, MAXP, MAXP, 1'b1, none);
    add_row(3'd7, MAXN, 1, 2, 3, 1'b1, none);
    // predictor-checked rows
    add_row(OP_MUL, MAXN, MAXN, MAXN, MAXN, 1'b0, none);
    add_row(OP_MUL, MAXP, MAXN, MAXP, MAXP, 1'b0, none);
    add_row(OP_MUL, 1, 1, 32'h0000_8000, 0, 1'b0, none);              // tie
    add_row(OP_MUL, 32'hFFFF_FFFF, 0, 32'h0000_8000, 0, 1'b0, none);  // neg tie
    add_row(OP_DIV, MAXP, MAXN, 1, 0, 1'b0, none);
    add_row(OP_DIV, MAXN, MAXP, MAXN, MAXN, 1'b0, none);
    add_row(OP_DIV, ONE, 0, 0, 32'h0003_0000, 1'b0, none);
    add_row(OP_DIV, 1, 32'hFFFF_FFFF, MAXP, MAXP, 1'b0, none);
    add_row(OP_DIV, 32'h0001_8000, 0, 32'h0003_0000, 0, 1'b0, none);
    add_row(OP_SUB, MAXN, MAXN, MAXN, MAXN, 1'b0, none);
    add_row(3'd6, 1, 2, 3, 4, 1'b0, none);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      want = directed[i].known ? directed[i].result : alu_result(directed[i].item);
      offer_item(directed[i].item, want);
    end

    // two idling phases and one without idling, then the long hold-off with items still offered
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 33 : 0;
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < ((ph == 3) ? 130 : 200); n++) begin
        x = rand_item();
        offer_item(x, alu_result(x));
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_fail == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_cell.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
verif/tb_complex_arithmetic_unit.sv
